/* hw/rtl/tpds_pkg.sv */
package tpds_pkg;

    localparam int NUM_PUMPS = 6;
    localparam int MAX_PUMPS = 8;
    localparam int PUMP_W    = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;
    localparam int IDX_W     = 3;
    localparam int MODE_W    = 3;
    localparam int MS_W      = 32;
    localparam int PIN_W     = 12;
    localparam int DRV_W     = 2;
    localparam int PH_W      = 2;

    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_TICK     = 3'd0;
    localparam t_mode MODE_STOP     = 3'd1;
    localparam t_mode MODE_RUN      = 3'd2;
    localparam t_mode MODE_DISPENSE = 3'd3;
    localparam t_mode MODE_STOP_ALL = 3'd4;
    localparam t_mode MODE_QUERY    = 3'd5;

    typedef logic [DRV_W-1:0] t_drive;
    localparam t_drive DRV_OFF = 2'd0;
    localparam t_drive DRV_FWD = 2'd1;
    localparam t_drive DRV_REV = 2'd2;

    typedef logic [PH_W-1:0] t_phase;
    localparam t_phase PH_IDLE = 2'd0;
    localparam t_phase PH_FWD  = 2'd1;
    localparam t_phase PH_REV  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef logic [NUM_PUMPS-1:0][DRV_W-1:0] t_drive_vec;

    // write request into the pump state file
    typedef struct packed {
        logic              clr_all;
        logic              we;
        logic [PUMP_W-1:0] idx;
        t_drive            drive;
        t_phase            phase;
        logic              dur_we;
        logic [MS_W-1:0]   fwd;
        logic [MS_W-1:0]   rev;
        logic              start_we;
        logic [MS_W-1:0]   start;
    } t_pump_wr;

    // one pump's state as read back
    typedef struct packed {
        t_drive          drive;
        t_phase          phase;
        logic [MS_W-1:0] start;
        logic [MS_W-1:0] fwd;
        logic [MS_W-1:0] rev;
    } t_pump_rd;

    // operands of the shared elapsed-time compare
    typedef struct packed {
        logic [MS_W-1:0] now;
        logic [MS_W-1:0] start;
        logic [MS_W-1:0] dur;
    } t_cmp_req;

    typedef struct packed {
        logic load;
        logic index_ok;
    } t_res_ctl;

endpackage

/* hw/rtl/tpds_channels.sv */
interface tpds_cmd_if import tpds_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  pump_index;
    logic              run_reverse;
    logic [MS_W-1:0]   forward_ms;
    logic [MS_W-1:0]   backward_ms;

    modport source (
        output valid, mode, pump_index, run_reverse, forward_ms, backward_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, pump_index, run_reverse, forward_ms, backward_ms,
        output ready
    );
endinterface

interface tpds_res_if import tpds_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] pin_image;
    logic [DRV_W-1:0] drive_state;
    logic             pump_busy;
    logic             index_ok;

    modport source (
        output valid, pin_image, drive_state, pump_busy, index_ok,
        input  ready
    );
    modport sink (
        input  valid, pin_image, drive_state, pump_busy, index_ok,
        output ready
    );
endinterface

/* hw/rtl/timed_pump_dispense_sequencer_top.sv */
// Channel   Dir  Handshake     Payload
// i_cmd     in   valid/ready   mode, pump_index, run_reverse, forward_ms, backward_ms
// o_res     out  valid/ready   pin_image, drive_state, pump_busy, index_ok
//
// A tick runs from accept through decode, then one pass over every pump
// (NUM_PUMPS) through the shared elapsed-time compare, then the result
// load, then back to idle; every other mode skips the pump pass.
// Reset (i_rst_n low, synchronous) clears the clock, all pump state and the
// result slot. A result waits in its output register while the next item is
// accepted; a stalled output only holds the sequencer in its result step.
module timed_pump_dispense_sequencer_top import tpds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpds_cmd_if.sink   i_cmd,
    tpds_res_if.source o_res
);

    t_pump_wr             wr;
    t_pump_rd             rd;
    t_drive_vec           drive_all;
    t_cmp_req             cmp;
    t_res_ctl             res_ctl;
    logic [PUMP_W-1:0]    rd_idx;
    logic                 elapsed_done;
    logic                 res_free;
    logic [2*MAX_PUMPS-1:0] pins_full;
    logic                 busy_now;

    logic             r_res_valid;
    logic [PIN_W-1:0] r_res_pins;
    t_drive           r_res_drive;
    logic             r_res_busy;
    logic             r_res_ok;

    // sequencer: decodes the item, walks the pumps on a tick
    tpds_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_res_free     (res_free),
        .i_elapsed_done (elapsed_done),
        .i_rd           (rd),
        .o_rd_idx       (rd_idx),
        .o_cmp          (cmp),
        .o_wr           (wr),
        .o_res_ctl      (res_ctl)
    );

    // per-pump drive, phase, start time and durations
    tpds_pump_file u_pump_file (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_rd_idx    (rd_idx),
        .o_rd        (rd),
        .o_drive_all (drive_all)
    );

    // one subtract-and-compare shared by every pump of the scan
    tpds_elapsed_cmp u_elapsed_cmp (
        .i_req  (cmp),
        .o_done (elapsed_done)
    );

    // pin image: forward drives A, reverse drives B; pumps past six drop out
    always_comb begin
        pins_full = '0;
        for (int p = 0; p < NUM_PUMPS; p++) begin
            unique case (drive_all[p])
                DRV_FWD: pins_full[2*p]     = 1'b1;
                DRV_REV: pins_full[2*p + 1] = 1'b1;
                default: ;
            endcase
        end
    end

    // the sequencer reads the addressed pump during its result step
    assign busy_now = (rd.phase != PH_IDLE) || (rd.drive != DRV_OFF);
    assign res_free = !r_res_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_ctl.load) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // hold the payload until the sink takes it
    always_ff @(posedge i_clk) begin
        if (res_ctl.load) begin
            r_res_pins  <= pins_full[PIN_W-1:0];
            r_res_drive <= res_ctl.index_ok ? rd.drive : DRV_OFF;
            r_res_busy  <= res_ctl.index_ok && busy_now;
            r_res_ok    <= res_ctl.index_ok;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.pin_image   = r_res_pins;
    assign o_res.drive_state = r_res_drive;
    assign o_res.pump_busy   = r_res_busy;
    assign o_res.index_ok    = r_res_ok;

    a_bad_index_reports_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res_ok) |-> (r_res_drive == DRV_OFF && !r_res_busy))
        else $error("out-of-range pump reported as driven or busy");

    a_driven_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_drive != DRV_OFF) |-> r_res_busy)
        else $error("driven pump reported not busy");

    a_res_held_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_res.ready) |=> (r_res_valid && $stable(r_res_pins)
            && $stable(r_res_drive) && $stable(r_res_busy) && $stable(r_res_ok)))
        else $error("waiting result changed before it was taken");

endmodule

/* hw/rtl/tpds_elapsed_cmp.sv */
module tpds_elapsed_cmp import tpds_pkg::*; (
    input  t_cmp_req i_req,
    output logic     o_done
);

    logic [MS_W-1:0] elapsed;

    // modulo-2^32 elapsed time, so a wrapped clock still measures right
    assign elapsed = i_req.now - i_req.start;
    assign o_done  = (elapsed >= i_req.dur);

endmodule

/* hw/rtl/tpds_pump_file.sv */
module tpds_pump_file import tpds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pump_wr          i_wr,
    input  logic [PUMP_W-1:0] i_rd_idx,
    output t_pump_rd          o_rd,
    output t_drive_vec        o_drive_all
);

    t_drive          r_drive [NUM_PUMPS];
    t_phase          r_phase [NUM_PUMPS];
    logic [MS_W-1:0] r_start [NUM_PUMPS];
    logic [MS_W-1:0] r_fwd   [NUM_PUMPS];
    logic [MS_W-1:0] r_rev   [NUM_PUMPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr_all) begin
            for (int p = 0; p < NUM_PUMPS; p++) begin
                r_drive[p] <= DRV_OFF;
                r_phase[p] <= PH_IDLE;
                r_start[p] <= '0;
                r_fwd[p]   <= '0;
                r_rev[p]   <= '0;
            end
        end else if (i_wr.we) begin
            r_drive[i_wr.idx] <= i_wr.drive;
            r_phase[i_wr.idx] <= i_wr.phase;
            if (i_wr.dur_we) begin
                r_fwd[i_wr.idx] <= i_wr.fwd;
                r_rev[i_wr.idx] <= i_wr.rev;
            end
            if (i_wr.start_we) begin
                r_start[i_wr.idx] <= i_wr.start;
            end
        end
    end

    always_comb begin
        o_rd.drive = r_drive[i_rd_idx];
        o_rd.phase = r_phase[i_rd_idx];
        o_rd.start = r_start[i_rd_idx];
        o_rd.fwd   = r_fwd[i_rd_idx];
        o_rd.rev   = r_rev[i_rd_idx];
        for (int p = 0; p < NUM_PUMPS; p++) begin
            o_drive_all[p] = r_drive[p];
        end
    end

endmodule

/* hw/rtl/tpds_ctrl.sv */
module tpds_ctrl import tpds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tpds_cmd_if.sink          i_cmd,
    input  logic              i_res_free,
    input  logic              i_elapsed_done,
    input  t_pump_rd          i_rd,
    output logic [PUMP_W-1:0] o_rd_idx,
    output t_cmp_req          o_cmp,
    output t_pump_wr          o_wr,
    output t_res_ctl          o_res_ctl
);

    localparam logic [PUMP_W-1:0] LAST_PUMP = PUMP_W'(NUM_PUMPS - 1);

    t_state            r_state, n_state;
    logic [PUMP_W-1:0] r_ptr, n_ptr;
    logic [MS_W-1:0]   r_clock, n_clock;
    t_mode             r_mode;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rev;
    logic [MS_W-1:0]   r_fwd;
    logic [MS_W-1:0]   r_bwd;
    logic              accept;
    logic              index_ok;
    logic [PUMP_W-1:0] pump;

    function automatic t_pump_wr halt_wr(input logic [PUMP_W-1:0] idx);
        t_pump_wr w;
        w          = '0;
        w.we       = 1'b1;
        w.idx      = idx;
        w.drive    = DRV_OFF;
        w.phase    = PH_IDLE;
        w.dur_we   = 1'b1;
        return w;
    endfunction

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign index_ok    = ({1'b0, r_idx} < (IDX_W + 1)'(NUM_PUMPS));
    assign pump        = r_idx[PUMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_clock <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_clock <= n_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_cmd.mode;
            r_idx  <= i_cmd.pump_index;
            r_rev  <= i_cmd.run_reverse;
            r_fwd  <= i_cmd.forward_ms;
            r_bwd  <= i_cmd.backward_ms;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = (r_mode == MODE_TICK) ? ST_SCAN : ST_RESP;
            end
            ST_SCAN: begin
                if (r_ptr == LAST_PUMP) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_res_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ptr           = r_ptr;
        n_clock         = r_clock;
        o_wr            = '0;
        o_res_ctl.load  = 1'b0;
        o_res_ctl.index_ok = index_ok;
        o_rd_idx        = (r_state == ST_SCAN) ? r_ptr : pump;
        o_cmp.now       = r_clock;
        o_cmp.start     = i_rd.start;
        o_cmp.dur       = (i_rd.phase == PH_FWD) ? i_rd.fwd : i_rd.rev;

        unique case (r_state)
            ST_IDLE: ;
            ST_EXEC: begin
                n_ptr = '0;
                case (r_mode)
                    MODE_TICK:     n_clock = r_clock + 1'b1;
                    MODE_STOP_ALL: o_wr.clr_all = 1'b1;
                    MODE_STOP: begin
                        if (index_ok) o_wr = halt_wr(pump);
                    end
                    MODE_RUN: begin
                        if (index_ok) begin
                            o_wr       = halt_wr(pump);
                            o_wr.drive = r_rev ? DRV_REV : DRV_FWD;
                        end
                    end
                    MODE_DISPENSE: begin
                        if (index_ok) begin
                            if (r_fwd == '0 && r_bwd == '0) begin
                                o_wr = halt_wr(pump);
                            end else begin
                                o_wr.we       = 1'b1;
                                o_wr.idx      = pump;
                                o_wr.dur_we   = 1'b1;
                                o_wr.fwd      = r_fwd;
                                o_wr.rev      = r_bwd;
                                o_wr.start_we = 1'b1;
                                o_wr.start    = r_clock;
                                o_wr.drive    = (r_fwd != '0) ? DRV_FWD : DRV_REV;
                                o_wr.phase    = (r_fwd != '0) ? PH_FWD : PH_REV;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                n_ptr = r_ptr + 1'b1;
                case (i_rd.phase)
                    PH_IDLE: ;
                    PH_FWD: begin
                        if (i_elapsed_done) begin
                            if (i_rd.rev != '0) begin
                                o_wr.we       = 1'b1;
                                o_wr.idx      = r_ptr;
                                o_wr.drive    = DRV_REV;
                                o_wr.phase    = PH_REV;
                                o_wr.start_we = 1'b1;
                                o_wr.start    = r_clock;
                            end else begin
                                o_wr = halt_wr(r_ptr);
                            end
                        end
                    end
                    PH_REV: begin
                        if (i_elapsed_done) o_wr = halt_wr(r_ptr);
                    end
                    default: o_wr = halt_wr(r_ptr);
                endcase
            end
            ST_RESP: begin
                o_res_ctl.load = i_res_free;
            end
            default: ;
        endcase
    end

    a_scan_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_ptr <= LAST_PUMP)
        else $error("pump pointer ran past the last pump");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_EXEC)
        else $error("accepted item did not start execution");

    a_tick_scans_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_mode == MODE_TICK) |=> (r_state == ST_SCAN && r_ptr == '0))
        else $error("tick did not start the pump scan at pump zero");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_RESP) |-> (!o_wr.we && !o_wr.clr_all))
        else $error("pump state written outside execution");

endmodule

/* sim/tb_timed_pump_dispense_sequencer_top.sv */
import tpds_pkg::*;

typedef struct packed {
    t_mode           mode;
    logic [IDX_W-1:0] pump_index;
    logic            run_reverse;
    logic [MS_W-1:0] forward_ms;
    logic [MS_W-1:0] backward_ms;
} t_dispense_cmd;

typedef struct packed {
    logic [PIN_W-1:0] pin_image;
    t_drive           drive_state;
    logic             pump_busy;
    logic             index_ok;
} t_pump_status;

class pump_dispense_board;
    logic [MS_W-1:0] now_ms;
    t_drive          drive[NUM_PUMPS];
    t_phase          phase[NUM_PUMPS];
    logic [MS_W-1:0] start_ms[NUM_PUMPS];
    logic [MS_W-1:0] fwd_ms[NUM_PUMPS];
    logic [MS_W-1:0] rev_ms[NUM_PUMPS];
    t_pump_status    awaiting[$];
    int              mismatches;
    int              checked;

    function new();
        now_ms     = '0;
        mismatches = 0;
        checked    = 0;
        stop_all();
    endfunction

    function void halt(int p);
        phase[p]  = PH_IDLE;
        fwd_ms[p] = '0;
        rev_ms[p] = '0;
        drive[p]  = DRV_OFF;
    endfunction

    function void stop_all();
        int p;
        for (p = 0; p < NUM_PUMPS; p++) begin
            halt(p);
            start_ms[p] = '0;
        end
    endfunction

    // Apply one accepted command to the pump state and queue the status it yields.
    function void note_cmd(t_dispense_cmd c);
        logic [MS_W-1:0] elapsed;
        t_pump_status    s;
        bit              ok;
        int              idx;
        int              p;
        ok  = (c.pump_index < NUM_PUMPS);
        idx = int'(c.pump_index);
        case (c.mode)
            MODE_TICK: begin
                now_ms = now_ms + 1;
                for (p = 0; p < NUM_PUMPS; p++) begin
                    elapsed = now_ms - start_ms[p];
                    case (phase[p])
                        PH_IDLE: ;
                        PH_FWD: begin
                            if (elapsed >= fwd_ms[p]) begin
                                if (rev_ms[p] != 0) begin
                                    phase[p]    = PH_REV;
                                    start_ms[p] = now_ms;
                                    drive[p]    = DRV_REV;
                                end else begin
                                    halt(p);
                                end
                            end
                        end
                        PH_REV: begin
                            if (elapsed >= rev_ms[p]) halt(p);
                        end
                        default: halt(p);
                    endcase
                end
            end
            MODE_STOP_ALL: stop_all();
            MODE_STOP: begin
                if (ok) halt(idx);
            end
            MODE_RUN: begin
                if (ok) begin
                    halt(idx);
                    drive[idx] = c.run_reverse ? DRV_REV : DRV_FWD;
                end
            end
            MODE_DISPENSE: begin
                if (ok) begin
                    if (c.forward_ms == 0 && c.backward_ms == 0) begin
                        halt(idx);
                    end else begin
                        fwd_ms[idx]   = c.forward_ms;
                        rev_ms[idx]   = c.backward_ms;
                        start_ms[idx] = now_ms;
                        if (c.forward_ms != 0) begin
                            phase[idx] = PH_FWD;
                            drive[idx] = DRV_FWD;
                        end else begin
                            phase[idx] = PH_REV;
                            drive[idx] = DRV_REV;
                        end
                    end
                end
            end
            default: ;
        endcase

        s = '0;
        for (p = 0; p < NUM_PUMPS; p++) begin
            if (2 * p + 1 < PIN_W) begin
                if (drive[p] == DRV_FWD) s.pin_image[2*p] = 1'b1;
                else if (drive[p] == DRV_REV) s.pin_image[2*p+1] = 1'b1;
            end
        end
        if (ok) begin
            s.drive_state = drive[idx];
            s.pump_busy   = (phase[idx] != PH_IDLE) || (drive[idx] != DRV_OFF);
            s.index_ok    = 1'b1;
        end
        awaiting.push_back(s);
    endfunction

    function void check_status(t_pump_status got);
        t_pump_status want;
        if (awaiting.size() == 0) begin
            $error("status with nothing expected: pin_image %h", got.pin_image);
            mismatches++;
            return;
        end
        want = awaiting.pop_front();
        checked++;
        if (got.pin_image !== want.pin_image) begin
            $error("pin_image: expected %h, actual %h", want.pin_image, got.pin_image);
            mismatches++;
        end
        if (got.drive_state !== want.drive_state) begin
            $error("drive_state: expected %0d, actual %0d", want.drive_state, got.drive_state);
            mismatches++;
        end
        if (got.pump_busy !== want.pump_busy) begin
            $error("pump_busy: expected %0d, actual %0d", want.pump_busy, got.pump_busy);
            mismatches++;
        end
        if (got.index_ok !== want.index_ok) begin
            $error("index_ok: expected %0d, actual %0d", want.index_ok, got.index_ok);
            mismatches++;
        end
    endfunction
endclass

module tb_timed_pump_dispense_sequencer_top;

    // Modes six and seven are unused by the block; they must behave as a query.
    localparam t_mode MODE_UNUSED_LO = 3'd6;
    localparam t_mode MODE_UNUSED_HI = 3'd7;

    // The run bound sits far above what the items and their idle pauses need;
    // the directed and random items fit inside it many times over.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    tpds_cmd_if cmd_ch ();
    tpds_res_if res_ch ();

    timed_pump_dispense_sequencer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    pump_dispense_board board;

    int cycles;
    int cmd_calm;
    int res_calm;
    int n_items;
    int n_ticks;
    int n_dispense;
    int n_off_range;

    always #2 i_clk = ~i_clk;

    // Bound the run: a hang anywhere ends here as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed_pump_dispense_sequencer_top test failed");
            $finish;
        end
    end

    // Draw a pause length; now and then enter a stretch of back-to-back items.
    function automatic int draw_pause(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Mostly short durations so phases elapse within a few ticks; sometimes
    // zero, sometimes a full 32-bit value that never elapses in this run.
    function automatic logic [MS_W-1:0] pick_ms();
        int roll;
        roll = $urandom_range(0, 11);
        if (roll == 0) return '0;
        if (roll == 1) return $urandom;
        return $urandom_range(0, 6);
    endfunction

    // Address a real pump most of the time, an absent one occasionally.
    function automatic logic [IDX_W-1:0] pick_pump();
        if ($urandom_range(0, 7) == 0)
            return IDX_W'($urandom_range(NUM_PUMPS, MAX_PUMPS - 1));
        return IDX_W'($urandom_range(0, NUM_PUMPS - 1));
    endfunction

    function automatic logic [IDX_W-1:0] any_pump();
        return IDX_W'($urandom_range(0, 7));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one item, hold it until accepted, then predict its status.
    task automatic send_cmd(input t_mode m, input logic [IDX_W-1:0] idx, input logic rev,
                            input logic [MS_W-1:0] fwd, input logic [MS_W-1:0] bwd);
        int            gap;
        t_dispense_cmd c;
        c.mode        = m;
        c.pump_index  = idx;
        c.run_reverse = rev;
        c.forward_ms  = fwd;
        c.backward_ms = bwd;
        gap = draw_pause(cmd_calm);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= m;
        cmd_ch.pump_index  <= idx;
        cmd_ch.run_reverse <= rev;
        cmd_ch.forward_ms  <= fwd;
        cmd_ch.backward_ms <= bwd;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        board.note_cmd(c);
        n_items++;
        if (m == MODE_TICK) n_ticks++;
        if (m == MODE_DISPENSE) n_dispense++;
        if (idx >= NUM_PUMPS) n_off_range++;
    endtask

    // Status sink: stall at random, check every accepted status in order.
    initial begin
        t_pump_status got;
        int           stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_pause(res_calm);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            got.pin_image   = res_ch.pin_image;
            got.drive_state = res_ch.drive_state;
            got.pump_busy   = res_ch.pump_busy;
            got.index_ok    = res_ch.index_ok;
            board.check_status(got);
        end
    end

    initial begin
        int roll;
        int n;
        board       = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        cycles      = 0;
        cmd_calm    = 0;
        res_calm    = 0;
        n_items     = 0;
        n_ticks     = 0;
        n_dispense  = 0;
        n_off_range = 0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.mode        = MODE_QUERY;
        cmd_ch.pump_index  = '0;
        cmd_ch.run_reverse = 1'b0;
        cmd_ch.forward_ms  = '0;
        cmd_ch.backward_ms = '0;

        // Hold reset, then release it once for good.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, field extremes, every mode, each corner case.
        send_cmd(MODE_QUERY, 3'd0, 1'b0, '0, '0);
        send_cmd(MODE_RUN, 3'd0, 1'b0, '0, '0);
        send_cmd(MODE_RUN, 3'd5, 1'b1, '1, '1);
        // out-of-range index: run and stop are dropped, status reports no drive, not busy, index not ok
        send_cmd(MODE_RUN, 3'd6, 1'b1, '0, '0);
        send_cmd(MODE_STOP, 3'd7, 1'b0, '0, '0);
        // timed run forward two ms then suck back one ms
        send_cmd(MODE_DISPENSE, 3'd1, 1'b0, 32'd2, 32'd1);
        // reverse only: starts reversing at once
        send_cmd(MODE_DISPENSE, 3'd3, 1'b0, 32'd0, 32'd2);
        // forward only: stops once the forward time is up
        send_cmd(MODE_DISPENSE, 3'd4, 1'b1, 32'd1, 32'd0);
        // ticks still report the pump named by the index
        send_cmd(MODE_TICK, 3'd1, 1'b0, '0, '0);
        send_cmd(MODE_TICK, 3'd7, 1'b1, '1, '1);
        send_cmd(MODE_TICK, 3'd3, 1'b0, '0, '0);
        send_cmd(MODE_TICK, 3'd1, 1'b0, '0, '0);
        // both times zero on a running pump stops it
        send_cmd(MODE_RUN, 3'd2, 1'b0, '0, '0);
        send_cmd(MODE_DISPENSE, 3'd2, 1'b0, '0, '0);
        // durations that never elapse, and a dispense to an absent pump
        send_cmd(MODE_DISPENSE, 3'd0, 1'b0, '1, '1);
        send_cmd(MODE_DISPENSE, 3'd7, 1'b1, 32'd3, 32'd3);
        send_cmd(MODE_UNUSED_LO, 3'd0, 1'b1, '1, '0);
        send_cmd(MODE_UNUSED_HI, 3'd5, 1'b0, '0, '1);
        send_cmd(MODE_TICK, 3'd0, 1'b0, '0, '0);
        send_cmd(MODE_STOP, 3'd0, 1'b0, '0, '0);
        send_cmd(MODE_QUERY, 3'd6, 1'b1, '1, '1);
        send_cmd(MODE_STOP_ALL, 3'd5, 1'b0, '0, '0);
        send_cmd(MODE_QUERY, 3'd5, 1'b0, '0, '0);

        // Random: mostly well-formed dispense/tick traffic so timed runs pass
        // through forward, reverse and stop; the rest is other modes and noise.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                send_cmd(MODE_TICK, any_pump(), any_bit(), $urandom, $urandom);
            else if (roll < 60)
                send_cmd(MODE_DISPENSE, pick_pump(), any_bit(), pick_ms(), pick_ms());
            else if (roll < 70)
                send_cmd(MODE_RUN, pick_pump(), any_bit(), $urandom, $urandom);
            else if (roll < 77)
                send_cmd(MODE_STOP, pick_pump(), any_bit(), $urandom, $urandom);
            else if (roll < 86)
                send_cmd(MODE_QUERY, any_pump(), any_bit(), $urandom, $urandom);
            else if (roll < 89)
                send_cmd(MODE_STOP_ALL, any_pump(), any_bit(), $urandom, $urandom);
            else if (roll < 93)
                send_cmd(any_bit() ? MODE_UNUSED_HI : MODE_UNUSED_LO,
                         any_pump(), any_bit(), $urandom, $urandom);
            else
                send_cmd(t_mode'($urandom_range(0, 7)), any_pump(), any_bit(),
                         $urandom, $urandom);
        end

        // Drop valid, drain the outstanding statuses, then allow a short tail.
        cmd_ch.valid <= 1'b0;
        while (board.awaiting.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands: %0d ticks, %0d timed dispenses, %0d absent pumps",
                 n_items, n_ticks, n_dispense, n_off_range);
        $display("compared %0d statuses, %0d field mismatches", board.checked,
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("timed_pump_dispense_sequencer_top test passed");
        end else begin
            $display("timed_pump_dispense_sequencer_top test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/tpds_pkg.sv
hw/rtl/tpds_channels.sv
hw/rtl/tpds_elapsed_cmp.sv
hw/rtl/tpds_pump_file.sv
hw/rtl/tpds_ctrl.sv
hw/rtl/timed_pump_dispense_sequencer_top.sv
sim/tb_timed_pump_dispense_sequencer_top.sv
